>>> hw/rtl/r2fft_pkg.sv
// Package with the shared types, constants and twiddle function of the radix-2 FFT unit.
package r2fft_pkg;
   localparam int SampleWidth = 16;
   localparam int BinWidth    = 28;
   localparam int CfgWidth    = 4;
   localparam logic [CfgWidth-1:0] LengthReset = 4'd10;

   typedef enum logic [0:0] {
      MODE_LOAD = 1'b0,
      MODE_READ = 1'b1
   } mode_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_FFT,
      ST_DRAIN,
      ST_READY
   } state_type;

   typedef struct packed {
      logic [BinWidth-1:0] re;
      logic [BinWidth-1:0] im;
   } cplx_type;

   typedef struct packed {
      logic signed [BinWidth-1:0] bin_real;
      logic signed [BinWidth-1:0] bin_imag;
      logic                       bin_valid;
      logic                       last_bin;
   } rsp_type;

   typedef struct packed {
      mode_type                      mode;
      logic signed [SampleWidth-1:0] sample_real;
      logic signed [SampleWidth-1:0] sample_imag;
   } req_type;

   // Unsigned 64-bit helpers for building the twiddle table at elaboration.
   function automatic longint unsigned mul62(input longint unsigned a,
                                             input longint unsigned b);
      longint unsigned al, ah, bl, bh, ll, lh, hl, hh, mid, lo, hi;
      begin
         al = a & 64'hFFFFFFFF; ah = a >> 32;
         bl = b & 64'hFFFFFFFF; bh = b >> 32;
         ll = al * bl; lh = al * bh; hl = ah * bl; hh = ah * bh;
         mid = (ll >> 32) + (lh & 64'hFFFFFFFF) + (hl & 64'hFFFFFFFF);
         lo = (mid << 32) | (ll & 64'hFFFFFFFF);
         hi = hh + (lh >> 32) + (hl >> 32) + (mid >> 32);
         return (hi << 2) | (lo >> 62);
      end
   endfunction

   // Shift-and-subtract quotient, used only while the twiddle table is built.
   function automatic longint unsigned udiv64(input longint unsigned num,
                                              input longint unsigned den);
      longint unsigned q, r;
      begin
         q = '0;
         r = '0;
         for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], num[b]};
            if (r >= den) begin
               r = r - den;
               q[b] = 1'b1;
            end
         end
         return q;
      end
   endfunction

   function automatic longint q62_tw(input longint unsigned v, input logic neg,
                                     input int tb);
      longint unsigned q, lim;
      begin
         q = (v + (64'd1 << (62 - tb))) >> (63 - tb);
         lim = (64'd1 << (tb - 1)) - 1;
         if (q > lim) q = lim;
         return neg ? -longint'(q) : longint'(q);
      end
   endfunction

   // Returns {cos, sin} of pi*m/2^lgh, each in the low tb bits.
   function automatic logic [47:0] twiddle(input int m, input int lgh, input int tb);
      longint unsigned half, quarter, ku, v, x, x2, st, s, ct, c;
      logic neg_cos, swap;
      longint cv, sv;
      logic [23:0] cw, sw;
      begin
         half = (64'd1 << lgh) >> 1;
         quarter = (64'd1 << lgh) >> 2;
         ku = (m <= half) ? m : (64'd1 << lgh) - m;
         neg_cos = (m > half);
         swap = (ku > quarter);
         v = swap ? half - ku : ku;
         x = mul62(64'hC90FDAA22168C235, v << (62 - lgh));
         x2 = mul62(x, x);
         st = x; s = x; ct = 64'd1 << 62; c = 64'd1 << 62;
         for (int j = 1; j <= 12; j++) begin
            st = udiv64(mul62(st, x2), 64'((2 * j) * (2 * j + 1)));
            ct = udiv64(mul62(ct, x2), 64'((2 * j - 1) * (2 * j)));
            if ((j & 1) == 1) begin
               s -= st; c -= ct;
            end else begin
               s += st; c += ct;
            end
         end
         cv = q62_tw(swap ? s : c, neg_cos, tb);
         sv = q62_tw(swap ? c : s, 1'b0, tb);
         cw = cv[23:0];
         sw = sv[23:0];
         return {cw, sw};
      end
   endfunction
endpackage

>>> hw/rtl/r2fft_req_if.sv
// Valid/ready channel interfaces for requests and results.
interface r2fft_req_if;
   logic                                    valid;
   logic                                    ready;
   r2fft_pkg::mode_type                     mode;
   logic signed [r2fft_pkg::SampleWidth-1:0] sample_real;
   logic signed [r2fft_pkg::SampleWidth-1:0] sample_imag;
   modport source (output valid, mode, sample_real, sample_imag, input ready);
   modport sink   (input valid, mode, sample_real, sample_imag, output ready);
endinterface

interface r2fft_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [r2fft_pkg::BinWidth-1:0] bin_real;
   logic signed [r2fft_pkg::BinWidth-1:0] bin_imag;
   logic                                  bin_valid;
   logic                                  last_bin;
   modport source (output valid, bin_real, bin_imag, bin_valid, last_bin, input ready);
   modport sink   (input valid, bin_real, bin_imag, bin_valid, last_bin, output ready);
endinterface

>>> hw/rtl/r2fft_butterfly.sv
// Complex butterfly with one register stage on the twiddle products; rounding, sum and difference follow it.
module r2fft_butterfly #(
   parameter int TWIDDLE_BITS = 16
) (
   input  logic                         clock,
   input  r2fft_pkg::cplx_type          even_in,
   input  r2fft_pkg::cplx_type          odd_in,
   input  logic signed [TWIDDLE_BITS-1:0] wr_in,
   input  logic signed [TWIDDLE_BITS-1:0] wi_in,
   output r2fft_pkg::cplx_type          sum_out,
   output r2fft_pkg::cplx_type          diff_out
);
   localparam int BW = r2fft_pkg::BinWidth;
   localparam int PW = BW + TWIDDLE_BITS;

   logic signed [PW-1:0] rr_ff, ii_ff, ri_ff, ir_ff;
   r2fft_pkg::cplx_type  even_ff;
   logic signed [PW:0]   pr_full, pi_full;
   logic signed [PW:0]   rnd;
   logic [BW-1:0]        pr, pi;

   always_ff @(posedge clock) begin
      rr_ff   <= PW'(signed'(odd_in.re)) * PW'(wr_in);
      ii_ff   <= PW'(signed'(odd_in.im)) * PW'(wi_in);
      ri_ff   <= PW'(signed'(odd_in.re)) * PW'(wi_in);
      ir_ff   <= PW'(signed'(odd_in.im)) * PW'(wr_in);
      even_ff <= even_in;
   end

   always_comb begin
      rnd     = (PW+1)'(1) <<< (TWIDDLE_BITS - 2);
      pr_full = ((PW+1)'(rr_ff) - (PW+1)'(ii_ff) + rnd) >>> (TWIDDLE_BITS - 1);
      pi_full = ((PW+1)'(ri_ff) + (PW+1)'(ir_ff) + rnd) >>> (TWIDDLE_BITS - 1);
      pr      = pr_full[BW-1:0];
      pi      = pi_full[BW-1:0];
      sum_out.re  = even_ff.re + pr;
      sum_out.im  = even_ff.im + pi;
      diff_out.re = even_ff.re - pr;
      diff_out.im = even_ff.im - pi;
   end
endmodule

>>> hw/rtl/radix2_complex_fft_unit.sv
// Top level of the in-place radix-2 decimation-in-time FFT unit.
// Load requests can be taken back to back. The load that completes a frame of N = 2^L samples
// starts the transform, which runs one butterfly per cycle out of a dual-port work memory
// (registered read, one register stage in the butterfly) and drains the butterfly pipeline
// after each stage; no request is taken during the transform. A read request's bin passes
// through the memory read register and then the result register, and no further request is
// taken until that bin has been accepted; a read with no finished frame returns zeros.
module radix2_complex_fft_unit #(
   parameter int MAX_POINTS   = 1024,
   parameter int TWIDDLE_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [r2fft_pkg::CfgWidth-1:0]  csr_write_data,
   r2fft_req_if.sink                       req,
   r2fft_rsp_if.source                     rsp
);
   localparam int LG   = (MAX_POINTS < 4) ? 1 : $clog2(MAX_POINTS);
   localparam int AW   = LG;
   localparam int HW   = (LG > 1) ? LG - 1 : 1;
   localparam int HALF = 1 << (LG - 1);
   localparam int BW   = r2fft_pkg::BinWidth;
   localparam int SW   = (LG < 2) ? 1 : $clog2(LG + 1);

   typedef logic [2*TWIDDLE_BITS-1:0] tw_word_type;
   function automatic tw_word_type tw_entry(input int m);
      logic [47:0] w;
      begin
         w = r2fft_pkg::twiddle(m, LG - 1, TWIDDLE_BITS);
         return {w[24+TWIDDLE_BITS-1:24], w[TWIDDLE_BITS-1:0]};
      end
   endfunction
   tw_word_type tw_rom [HALF];
   for (genvar g = 0; g < HALF; g++) begin : g_rom
      assign tw_rom[g] = tw_entry(g);
   end

   r2fft_pkg::cplx_type mem [1 << AW];

   r2fft_pkg::state_type state_ff, state_in;
   logic [r2fft_pkg::CfgWidth-1:0] len_cfg_ff;
   logic [AW:0]  load_count_ff, load_count_in;
   logic [AW-1:0] read_index_ff, read_index_in;
   logic          frame_done_ff, frame_done_in;
   logic [SW-1:0] stage_ff, stage_in;
   logic [AW-1:0] bf_ff, bf_in;
   logic [3:0]    drain_ff, drain_in;

   logic [SW-1:0] len;
   logic [AW:0]   npts;

   logic          rd_en;
   logic [AW-1:0] rd_a, rd_b;
   r2fft_pkg::cplx_type rd_a_ff, rd_b_ff;
   logic          wr_en;
   logic [AW-1:0] wr_a, wr_b;
   r2fft_pkg::cplx_type wr_da, wr_db;
   logic          wr2_en;

   logic [AW-1:0] e_addr, o_addr, load_addr;
   logic [HW-1:0] tw_idx;
   logic [AW-1:0] pipe_e_ff [2], pipe_o_ff [2];
   logic [1:0]    pipe_v_ff;
   logic signed [TWIDDLE_BITS-1:0] wr_ff, wi_ff;
   r2fft_pkg::cplx_type sum_w, diff_w;

   logic          out_v_ff, out_pend_ff, out_pend_in;
   r2fft_pkg::rsp_type out_ff, out_in;
   logic          rd_pend_ff, rd_last_ff, rd_empty_ff;
   logic          req_fire;

   always_comb begin
      if (len_cfg_ff == '0) len = SW'(1);
      else if (32'(len_cfg_ff) > LG) len = SW'(LG);
      else len = SW'(len_cfg_ff);
      npts = (AW+1)'(1) << len;
   end

   always_comb begin
      load_addr = '0;
      for (int b = 0; b < AW; b++) begin
         if (b < 32'(len)) load_addr[32'(len) - 1 - b] = load_count_ff[b];
      end
   end

   always_comb begin
      logic [AW:0] n;
      logic [AW:0] i;
      logic [AW:0] start;
      n      = (AW+1)'(1) << stage_ff;
      i      = (AW+1)'(bf_ff) & (n - 1'b1);
      start  = ((AW+1)'(bf_ff) - i) << 1;
      e_addr = AW'(start + i);
      o_addr = AW'(start + i + n);
      tw_idx = HW'(i << (LG - 1 - 32'(stage_ff)));
   end

   assign req_fire = req.valid && req.ready;
   assign req.ready = (state_ff == r2fft_pkg::ST_LOAD || state_ff == r2fft_pkg::ST_READY)
                      && !out_pend_ff && !rd_pend_ff;

   always_comb begin
      state_in      = state_ff;
      load_count_in = load_count_ff;
      read_index_in = read_index_ff;
      frame_done_in = frame_done_ff;
      stage_in      = stage_ff;
      bf_in         = bf_ff;
      drain_in      = drain_ff;
      rd_en = 1'b0; rd_a = e_addr; rd_b = o_addr;
      wr_en = 1'b0; wr2_en = 1'b0;
      wr_a = pipe_e_ff[1]; wr_b = pipe_o_ff[1];
      wr_da = sum_w; wr_db = diff_w;
      unique case (state_ff)
         r2fft_pkg::ST_LOAD, r2fft_pkg::ST_READY: begin
            if (req_fire && req.mode == r2fft_pkg::MODE_LOAD) begin
               wr_en = 1'b1;
               wr_a = load_addr;
               wr_da.re = BW'(req.sample_real);
               wr_da.im = BW'(req.sample_imag);
               frame_done_in = 1'b0;
               read_index_in = '0;
               if (load_count_ff + 1'b1 == npts) begin
                  load_count_in = '0;
                  stage_in = '0;
                  bf_in = '0;
                  state_in = r2fft_pkg::ST_FFT;
               end else begin
                  load_count_in = load_count_ff + 1'b1;
                  state_in = r2fft_pkg::ST_LOAD;
               end
            end else if (req_fire && frame_done_ff) begin
               rd_en = 1'b1;
               rd_a = read_index_ff;
               if ((AW+1)'(read_index_ff) == npts - 1'b1) begin
                  read_index_in = '0;
                  frame_done_in = 1'b0;
                  state_in = r2fft_pkg::ST_LOAD;
               end else begin
                  read_index_in = read_index_ff + 1'b1;
               end
            end
         end
         r2fft_pkg::ST_FFT: begin
            rd_en = 1'b1;
            wr_en = pipe_v_ff[1];
            wr2_en = pipe_v_ff[1];
            if ((AW+1)'(bf_ff) == (npts >> 1) - 1'b1) begin
               bf_in = '0;
               drain_in = 4'd0;
               state_in = r2fft_pkg::ST_DRAIN;
            end else begin
               bf_in = bf_ff + 1'b1;
            end
         end
         r2fft_pkg::ST_DRAIN: begin
            wr_en = pipe_v_ff[1];
            wr2_en = pipe_v_ff[1];
            drain_in = drain_ff + 1'b1;
            if (drain_ff == 4'd3) begin
               if (stage_ff + 1'b1 == len) begin
                  frame_done_in = 1'b1;
                  read_index_in = '0;
                  state_in = r2fft_pkg::ST_READY;
               end else begin
                  stage_in = stage_ff + 1'b1;
                  state_in = r2fft_pkg::ST_FFT;
               end
            end
         end
         default: state_in = r2fft_pkg::ST_LOAD;
      endcase
      if (csr_write_enable) begin
         load_count_in = '0;
         read_index_in = '0;
         frame_done_in = 1'b0;
         state_in = r2fft_pkg::ST_LOAD;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem[rd_a];
         rd_b_ff <= mem[rd_b];
      end
      if (wr_en) mem[wr_a] <= wr_da;
      if (wr2_en) mem[wr_b] <= wr_db;
   end

   always_ff @(posedge clock) begin
      pipe_e_ff[0] <= e_addr;
      pipe_o_ff[0] <= o_addr;
      pipe_e_ff[1] <= pipe_e_ff[0];
      pipe_o_ff[1] <= pipe_o_ff[0];
      {wr_ff, wi_ff} <= tw_rom[tw_idx];
   end

   r2fft_butterfly #(.TWIDDLE_BITS(TWIDDLE_BITS)) u_bfly (
      .clock    (clock),
      .even_in  (rd_a_ff),
      .odd_in   (rd_b_ff),
      .wr_in    (wr_ff),
      .wi_in    (wi_ff),
      .sum_out  (sum_w),
      .diff_out (diff_w)
   );

   always_comb begin
      out_in = out_ff;
      out_pend_in = out_pend_ff;
      if (rsp.valid && rsp.ready) out_pend_in = 1'b0;
      if (rd_pend_ff) begin
         out_in.bin_real  = rd_empty_ff ? '0 : signed'(rd_a_ff.re);
         out_in.bin_imag  = rd_empty_ff ? '0 : signed'(rd_a_ff.im);
         out_in.bin_valid = !rd_empty_ff;
         out_in.last_bin  = rd_last_ff && !rd_empty_ff;
         out_pend_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= r2fft_pkg::ST_LOAD;
         len_cfg_ff    <= r2fft_pkg::LengthReset;
         load_count_ff <= '0;
         read_index_ff <= '0;
         frame_done_ff <= 1'b0;
         stage_ff      <= '0;
         bf_ff         <= '0;
         drain_ff      <= '0;
         pipe_v_ff     <= '0;
         rd_pend_ff    <= 1'b0;
         out_pend_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         if (csr_write_enable) len_cfg_ff <= csr_write_data;
         load_count_ff <= load_count_in;
         read_index_ff <= read_index_in;
         frame_done_ff <= frame_done_in;
         stage_ff      <= stage_in;
         bf_ff         <= bf_in;
         drain_ff      <= drain_in;
         pipe_v_ff     <= {pipe_v_ff[0], state_ff == r2fft_pkg::ST_FFT};
         rd_pend_ff    <= req_fire && req.mode == r2fft_pkg::MODE_READ;
         out_pend_ff   <= out_pend_in;
      end
      rd_last_ff  <= (AW+1)'(read_index_ff) == npts - 1'b1;
      rd_empty_ff <= !frame_done_ff;
      out_ff      <= out_in;
   end

   assign out_v_ff      = out_pend_ff;
   assign rsp.valid     = out_v_ff;
   assign rsp.bin_real  = out_ff.bin_real;
   assign rsp.bin_imag  = out_ff.bin_imag;
   assign rsp.bin_valid = out_ff.bin_valid;
   assign rsp.last_bin  = out_ff.last_bin;
endmodule

>>> hw/rtl/r2fft_checker.sv
// Port-level assertions for the FFT unit and their bind.
module r2fft_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_bin_valid,
   input logic rsp_last_bin
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");
   a_last_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_bin |-> rsp_bin_valid) else $error("last without bin");
   a_no_take: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request taken with result pending");
endmodule

bind radix2_complex_fft_unit r2fft_checker u_chk (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_bin_valid(rsp.bin_valid), .rsp_last_bin(rsp.last_bin)
);
